@@ design/spiee_pkg.sv @@
package spiee_pkg;

  localparam int BUF_DEPTH = 256;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_READ,
    MODE_WRITE,
    MODE_ERASE,
    MODE_WRITE_WAIT,
    MODE_ERASE_WAIT,
    MODE_READ_ST,
    MODE_WRITE_ST
  } mode_t;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_ERASE     = 3'd2;
  localparam logic [2:0] OP_RD_STATUS = 3'd3;
  localparam logic [2:0] OP_WR_STATUS = 3'd4;
  localparam logic [2:0] OP_SPI_DONE  = 3'd5;
  localparam logic [2:0] OP_LOAD      = 3'd6;

  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] ERASE_FILL = 8'hFF;

  localparam logic CFG_PAGE_SIZE_LOG2 = 1'b0;
  localparam logic CFG_POLL_LIMIT     = 1'b1;

  localparam logic [15:0] TIMEOUT_CODE = 16'hFFFF;

  typedef struct packed {
    logic        accepted;
    logic        busy_res;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_cycle;
    logic        cs_release;
    logic        rd_valid;
    logic [7:0]  rd_index;
    logic [7:0]  rd_byte;
    logic        done_res;
    logic        error;
    logic [15:0] done_code;
  } res_t;

endpackage

@@ design/spi_eeprom_command_sequencer_core.sv @@
// Command sequencer for a 25xx-style SPI EEPROM.
// The input channel (in_valid/in_stall) carries start words (read, write, erase,
// status read, status write), spi_done words that hand in the received byte, and
// buffer load words. Every accepted input word yields exactly one result word on
// the output channel (out_valid/out_stall), naming the next byte to shift out and
// any chip-select action, plus read data and completion status.
// The result word is registered and presented in the cycle after the input word
// is accepted. Throughput is one word per cycle; the only limit is the single
// output register, so in_stall is high only while a result word waits and
// out_stall is high. When the receiver stalls, the result word and its fields hold.
// The write data buffer is a BUF_DEPTH-byte memory with one write and one
// registered read port; its contents are undefined until loaded.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes page_size_log2 at
// index 0 and poll_limit at index 1; write it only while the block is idle.
// Synchronous reset returns the sequencer to idle, restores page_size_log2 to 5
// and poll_limit to 1000, and empties the output register.
module spi_eeprom_command_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_address,
  input  logic [8:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_buf_index,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_busy_res,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_cs_cycle,
  output logic        out_cs_release,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_index,
  output logic [7:0]  out_rd_byte,
  output logic        out_done_res,
  output logic        out_error,
  output logic [15:0] out_done_code
);
  import spiee_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic [3:0]    page_size_log2_r;
  logic [15:0]   poll_limit_r;
  mode_t         mode_r, mode_nxt;
  logic [8:0]    step_r, step_nxt;
  logic [15:0]   poll_count_r, poll_count_nxt;
  logic [15:0]   cur_address_r, cur_address_nxt;
  logic [8:0]    remaining_r, remaining_nxt;
  logic [7:0]    status_r, status_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;

  logic [7:0]    wbuf [BUF_DEPTH];
  logic [7:0]    mem_q_r;

  res_t          res;
  res_t          res_r;
  logic          use_mem, use_mem_r;
  logic          out_valid_r;

  logic          in_acc;
  logic          len_ok;
  logic          load_ok;
  logic [AW-1:0] wr_addr;
  logic [8:0]    c;
  logic [15:0]   page_mask;
  logic [15:0]   adr_sum;
  logic          page_edge;
  logic          piece_end;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign len_ok   = (in_length != 9'd0) && (in_length <= 9'd256);
  assign load_ok  = 32'(in_buf_index) < BUF_DEPTH;
  assign wr_addr  = AW'(in_buf_index);

  assign c         = step_r - 9'd3;
  assign page_mask = (16'd1 << page_size_log2_r) - 16'd1;
  assign adr_sum   = cur_address_r + 16'(c);
  assign page_edge = (c != 9'd0) && ((adr_sum & page_mask) == 16'd0);
  assign piece_end = page_edge || (c >= remaining_r);

  always_comb begin
    res             = '0;
    use_mem         = 1'b0;
    mode_nxt        = mode_r;
    step_nxt        = step_r;
    poll_count_nxt  = poll_count_r;
    cur_address_nxt = cur_address_r;
    remaining_nxt   = remaining_r;
    status_nxt      = status_r;
    rd_ptr_nxt      = rd_ptr_r;

    case (in_op)
      OP_READ, OP_WRITE, OP_ERASE, OP_RD_STATUS, OP_WR_STATUS: begin
        if ((mode_r == MODE_IDLE) &&
            (len_ok || in_op == OP_RD_STATUS || in_op == OP_WR_STATUS)) begin
          res.accepted   = 1'b1;
          res.tx_valid   = 1'b1;
          step_nxt       = '0;
          poll_count_nxt = '0;
          case (in_op)
            OP_READ: begin
              mode_nxt        = MODE_READ;
              cur_address_nxt = in_address;
              remaining_nxt   = in_length;
              res.tx_byte     = CMD_READ;
            end
            OP_WRITE, OP_ERASE: begin
              mode_nxt        = (in_op == OP_WRITE) ? MODE_WRITE : MODE_ERASE;
              cur_address_nxt = in_address;
              remaining_nxt   = in_length;
              rd_ptr_nxt      = '0;
              res.tx_byte     = CMD_WREN;
            end
            OP_RD_STATUS: begin
              mode_nxt    = MODE_READ_ST;
              res.tx_byte = CMD_RDSR;
            end
            default: begin
              mode_nxt      = MODE_WRITE_ST;
              remaining_nxt = '0;
              status_nxt    = in_data_byte;
              res.tx_byte   = CMD_WREN;
            end
          endcase
        end
      end

      OP_SPI_DONE: begin
        case (mode_r)
          MODE_READ: begin
            step_nxt = step_r + 9'd1;
            if (step_r == 9'd0) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cur_address_r[15:8];
            end else if (step_r == 9'd1) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cur_address_r[7:0];
            end else if (step_r == 9'd2) begin
              res.tx_valid = 1'b1;
            end else begin
              res.rd_valid = 1'b1;
              res.rd_index = c[7:0];
              res.rd_byte  = in_rx_byte;
              if (({1'b0, c} + 10'd1) >= {1'b0, remaining_r}) begin
                res.cs_release = 1'b1;
                res.done_res   = 1'b1;
                res.done_code  = 16'(remaining_r);
                mode_nxt       = MODE_IDLE;
                step_nxt       = '0;
              end else begin
                res.tx_valid = 1'b1;
              end
            end
          end

          MODE_WRITE, MODE_ERASE: begin
            step_nxt = step_r + 9'd1;
            if (step_r == 9'd0) begin
              res.cs_cycle = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = CMD_WRITE;
            end else if (step_r == 9'd1) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cur_address_r[15:8];
            end else if (step_r == 9'd2) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cur_address_r[7:0];
            end else if (piece_end) begin
              remaining_nxt   = (c >= remaining_r) ? 9'd0 : remaining_r - c;
              cur_address_nxt = adr_sum;
              res.cs_cycle    = 1'b1;
              res.tx_valid    = 1'b1;
              res.tx_byte     = CMD_RDSR;
              mode_nxt        = (mode_r == MODE_ERASE) ? MODE_ERASE_WAIT : MODE_WRITE_WAIT;
              poll_count_nxt  = '0;
              step_nxt        = '0;
            end else if (mode_r == MODE_WRITE) begin
              res.tx_valid = 1'b1;
              use_mem      = 1'b1;
              rd_ptr_nxt   = (rd_ptr_r == AW'(BUF_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = ERASE_FILL;
            end
          end

          MODE_WRITE_WAIT, MODE_ERASE_WAIT: begin
            poll_count_nxt = poll_count_r + 16'd1;
            if (poll_count_r[0]) begin
              if (poll_count_r > poll_limit_r) begin
                res.cs_release = 1'b1;
                res.done_res   = 1'b1;
                res.error      = 1'b1;
                res.done_code  = TIMEOUT_CODE;
                mode_nxt       = MODE_IDLE;
                poll_count_nxt = poll_count_r;
              end else if (in_rx_byte[0]) begin
                res.cs_cycle = 1'b1;
                res.tx_valid = 1'b1;
                res.tx_byte  = CMD_RDSR;
              end else if (remaining_r != 9'd0) begin
                res.cs_cycle = 1'b1;
                res.tx_valid = 1'b1;
                res.tx_byte  = CMD_WREN;
                step_nxt     = '0;
                mode_nxt     = (mode_r == MODE_WRITE_WAIT) ? MODE_WRITE : MODE_ERASE;
              end else begin
                res.cs_release = 1'b1;
                res.done_res   = 1'b1;
                res.done_code  = poll_count_r;
                mode_nxt       = MODE_IDLE;
                poll_count_nxt = poll_count_r;
              end
            end else begin
              res.tx_valid = 1'b1;
            end
          end

          MODE_READ_ST: begin
            if (step_r == 9'd0) begin
              res.tx_valid = 1'b1;
              step_nxt     = 9'd1;
            end else begin
              res.cs_release = 1'b1;
              res.done_res   = 1'b1;
              res.done_code  = 16'(in_rx_byte);
              mode_nxt       = MODE_IDLE;
              step_nxt       = '0;
            end
          end

          MODE_WRITE_ST: begin
            if (step_r == 9'd0) begin
              res.cs_cycle = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = CMD_WRSR;
              step_nxt     = 9'd1;
            end else if (step_r == 9'd1) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = status_r;
              step_nxt     = 9'd2;
            end else begin
              remaining_nxt  = '0;
              res.cs_cycle   = 1'b1;
              res.tx_valid   = 1'b1;
              res.tx_byte    = CMD_RDSR;
              mode_nxt       = MODE_WRITE_WAIT;
              poll_count_nxt = '0;
              step_nxt       = '0;
            end
          end

          default: begin
          end
        endcase
      end

      OP_LOAD: begin
        res.accepted = load_ok;
      end

      default: begin
      end
    endcase

    res.busy_res = (mode_nxt != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_log2_r <= 4'd5;
      poll_limit_r     <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SIZE_LOG2: page_size_log2_r <= cfg_wdata[3:0];
        CFG_POLL_LIMIT:     poll_limit_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      step_r        <= '0;
      poll_count_r  <= '0;
      cur_address_r <= '0;
      remaining_r   <= '0;
      status_r      <= '0;
      rd_ptr_r      <= '0;
    end else if (in_acc) begin
      mode_r        <= mode_nxt;
      step_r        <= step_nxt;
      poll_count_r  <= poll_count_nxt;
      cur_address_r <= cur_address_nxt;
      remaining_r   <= remaining_nxt;
      status_r      <= status_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_LOAD && load_ok) begin
      wbuf[wr_addr] <= in_data_byte;
    end
    if (in_acc) begin
      mem_q_r <= wbuf[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r     <= res;
      use_mem_r <= use_mem;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = res_r.accepted;
  assign out_busy_res   = res_r.busy_res;
  assign out_tx_valid   = res_r.tx_valid;
  assign out_tx_byte    = use_mem_r ? mem_q_r : res_r.tx_byte;
  assign out_cs_cycle   = res_r.cs_cycle;
  assign out_cs_release = res_r.cs_release;
  assign out_rd_valid   = res_r.rd_valid;
  assign out_rd_index   = res_r.rd_index;
  assign out_rd_byte    = res_r.rd_byte;
  assign out_done_res   = res_r.done_res;
  assign out_error      = res_r.error;
  assign out_done_code  = res_r.done_code;

endmodule
